// ===== sv/cltw_pkg.sv =====
// Shared types, constants and the init command table of the character-LCD text writer.
// Depends on nothing; the queue, front, back and top level import it.
`default_nettype none

package cltw_pkg;

  // Geometry defaults and fixed field widths.
  localparam int NUM_COLS_DFLT = 16;
  localparam int NUM_ROWS_DFLT = 2;
  localparam int COL_W         = 6;
  localparam int CONTRAST_W    = 6;
  localparam logic [CONTRAST_W-1:0] CONTRAST_RST = 6'd32;

  // Decimal conversion.
  localparam int INT_W  = 32;
  localparam int NDIG   = 10;
  localparam int BCD_W  = 4 * NDIG;
  localparam int IDX_W  = 4;

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;

  // Request kinds as they arrive on the input channel.
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_SETCUR = 3'd2;
  localparam logic [2:0] KIND_CHAR   = 3'd3;
  localparam logic [2:0] KIND_INT    = 3'd4;

  // Panel command bytes.
  localparam logic [7:0] CMD_FUNC_SET     = 8'h38;
  localparam logic [7:0] CMD_FUNC_SET_EXT = 8'h39;
  localparam logic [7:0] CMD_OSC          = 8'h14;
  localparam logic [7:0] CMD_CONTRAST_LO  = 8'h70;
  localparam logic [7:0] CMD_POWER_ICON   = 8'h5C;
  localparam logic [7:0] CMD_FOLLOWER     = 8'h6C;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  localparam int INIT_LEN = 10;

  // Characters with a special role.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

  // Pauses in milliseconds.
  localparam logic [7:0] PAUSE_POWER_MS = 8'd40;
  localparam logic [7:0] PAUSE_INIT_MS  = 8'd200;
  localparam logic [1:0] PAUSE_CLEAR_MS = 2'd2;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_CLEAR,
    OP_SETCUR,
    OP_CHAR,
    OP_INT
  } op_t;

  // One queued operation, already classified and clamped by the front.
  typedef struct packed {
    op_t              op;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col;
    logic             row;
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [IDX_W-1:0] top_idx;
  } entry_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] before_ms;
    logic [1:0] after_ms;
  } init_cmd_t;

  function automatic init_cmd_t init_cmd(input logic [IDX_W-1:0] step,
                                         input logic [CONTRAST_W-1:0] contrast);
    init_cmd_t c;
    c = '0;
    unique case (step)
      4'd0: c = '{CMD_FUNC_SET, PAUSE_POWER_MS, 2'd0};
      4'd1: c = '{CMD_FUNC_SET_EXT, 8'd0, 2'd0};
      4'd2: c = '{CMD_OSC, 8'd0, 2'd0};
      4'd3: c = '{CMD_CONTRAST_LO | {4'd0, contrast[3:0]}, 8'd0, 2'd0};
      4'd4: c = '{CMD_POWER_ICON | {6'd0, contrast[5:4]}, 8'd0, 2'd0};
      4'd5: c = '{CMD_FOLLOWER, 8'd0, 2'd0};
      4'd6: c = '{CMD_FUNC_SET, PAUSE_INIT_MS, 2'd0};
      4'd7: c = '{CMD_DISPLAY_ON, 8'd0, 2'd0};
      4'd8: c = '{CMD_CLEAR, 8'd0, PAUSE_CLEAR_MS};
      4'd9: c = '{CMD_ENTRY_MODE, 8'd0, 2'd0};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cltw_ifs.sv =====
// Valid/ready channel interfaces for requests and panel transfers.
// Depends on nothing; the front, back and top level use them.
`default_nettype none

interface cltw_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         char_code;
  logic [7:0]         col;
  logic [7:0]         row;
  logic signed [31:0] int_value;

  modport source(output valid, kind, char_code, col, row, int_value, input ready);
  modport sink(input valid, kind, char_code, col, row, int_value, output ready);
endinterface

interface cltw_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] byte_value;
  logic [7:0] pause_before_ms;
  logic [1:0] pause_after_ms;
  logic       last;

  modport source(output valid, is_data, byte_value, pause_before_ms, pause_after_ms, last,
                 input ready);
  modport sink(input valid, is_data, byte_value, pause_before_ms, pause_after_ms, last,
               output ready);
endinterface

`default_nettype wire

// ===== sv/cltw_queue.sv =====
// Short queue of classified operations between the front and the back.
// Depends on cltw_pkg.
`default_nettype none

module cltw_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  cltw_pkg::entry_t     wdata,
  output logic                 full,
  input  wire logic            pop,
  output cltw_pkg::entry_t     rdata,
  output logic                 empty
);
  import cltw_pkg::*;

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  entry_t           mem_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign full  = (count_r == QCW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cltw_front.sv =====
// Front end: accepts request words, clamps positions, converts integers to BCD
// and queues one operation per request of a known kind. Depends on cltw_pkg and cltw_ifs.
`default_nettype none

module cltw_front #(
  parameter int NUM_COLS = cltw_pkg::NUM_COLS_DFLT,
  parameter int NUM_ROWS = cltw_pkg::NUM_ROWS_DFLT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cltw_in_if.sink          in_if,
  output logic             push,
  output cltw_pkg::entry_t wdata,
  input  wire logic        q_full
);
  import cltw_pkg::*;

  localparam int CNT_W = $clog2(INT_W + 1);

  typedef enum logic {F_IDLE, F_CONV} fstate_t;

  fstate_t          state_r, state_nxt;
  logic [INT_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;

  logic             accept;
  logic             conv_done;
  logic [BCD_W-1:0] bcd_adj;
  logic [IDX_W-1:0] top_idx;
  logic [INT_W-1:0] in_mag;
  logic             in_neg;

  assign in_if.ready = (state_r == F_IDLE) && !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign conv_done   = (cnt_r == CNT_W'(INT_W));
  assign in_neg      = in_if.int_value[INT_W-1];
  assign in_mag      = in_neg ? (~in_if.int_value + 1'b1) : in_if.int_value;

  // Double-dabble: every digit of five or more gets three added before the shift.
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // Position of the most significant nonzero digit; zero prints as one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    push      = 1'b0;
    wdata     = '0;
    wdata.op  = OP_INIT;
    unique case (state_r)
      F_IDLE: begin
        wdata.char_code = in_if.char_code;
        wdata.col = (in_if.col >= 8'(NUM_COLS)) ? COL_W'(NUM_COLS - 1)
                                                : in_if.col[COL_W-1:0];
        wdata.row = (in_if.row >= 8'(NUM_ROWS)) ? 1'(NUM_ROWS - 1) : in_if.row[0];
        if (accept) begin
          unique case (in_if.kind)
            KIND_INIT: begin
              push = 1'b1;
              wdata.op = OP_INIT;
            end
            KIND_CLEAR: begin
              push = 1'b1;
              wdata.op = OP_CLEAR;
            end
            KIND_SETCUR: begin
              push = 1'b1;
              wdata.op = OP_SETCUR;
            end
            KIND_CHAR: begin
              push = 1'b1;
              wdata.op = OP_CHAR;
            end
            KIND_INT: begin
              bin_nxt   = in_mag;
              bcd_nxt   = '0;
              cnt_nxt   = '0;
              neg_nxt   = in_neg;
              state_nxt = F_CONV;
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      F_CONV: begin
        if (!conv_done) begin
          bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[INT_W-1]};
          bin_nxt = {bin_r[INT_W-2:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
        end else if (!q_full) begin
          push          = 1'b1;
          wdata.op      = OP_INT;
          wdata.neg     = neg_r;
          wdata.bcd     = bcd_r;
          wdata.top_idx = top_idx;
          state_nxt     = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  // An integer request holds the input off while its digits are worked out.
  a_int_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_if.kind == KIND_INT) |=> !in_if.ready)
    else $error("front took a word while converting an integer");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("front pushed into a full queue");

endmodule

`default_nettype wire

// ===== sv/cltw_back.sv =====
// Back end: expands queued operations into panel transfers, tracks the cursor
// and holds the output register. Depends on cltw_pkg and cltw_ifs.
`default_nettype none

module cltw_back #(
  parameter int NUM_COLS = cltw_pkg::NUM_COLS_DFLT,
  parameter int NUM_ROWS = cltw_pkg::NUM_ROWS_DFLT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  cltw_pkg::entry_t                     rdata,
  input  wire logic                            q_empty,
  output logic                                 pop,
  input  wire logic [cltw_pkg::CONTRAST_W-1:0] contrast,
  cltw_out_if.source                           out_if
);
  import cltw_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_INIT, ST_CLEAR, ST_ADDR, ST_CHAR} bstate_t;

  bstate_t          state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_r, row_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             is_int_r, is_int_nxt;
  logic             neg_pend_r, neg_pend_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             addr_last_r, addr_last_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_is_data_r, out_is_data_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [7:0]       out_before_r, out_before_nxt;
  logic [1:0]       out_after_r, out_after_nxt;
  logic             out_last_r, out_last_nxt;

  logic             emit_ok;
  logic             row_next;
  logic [7:0]       cur_char;
  logic             more;
  logic             wrap;
  init_cmd_t        icmd;

  assign emit_ok  = !out_valid_r || out_if.ready;
  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign row_next = (NUM_ROWS > 1) ? ~row_r : 1'b0;
  assign cur_char = !is_int_r  ? char_r :
                    neg_pend_r ? CHAR_MINUS : {CHAR_DIGIT_HI, bcd_r[{idx_r, 2'b00} +: 4]};
  assign more     = is_int_r && (neg_pend_r || (idx_r != '0));
  assign wrap     = (col_r == COL_W'(NUM_COLS - 1));
  assign icmd     = init_cmd(step_r, contrast);

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    char_nxt        = char_r;
    is_int_nxt      = is_int_r;
    neg_pend_nxt    = neg_pend_r;
    idx_nxt         = idx_r;
    bcd_nxt         = bcd_r;
    addr_last_nxt   = addr_last_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_is_data_nxt = out_is_data_r;
    out_byte_nxt    = out_byte_r;
    out_before_nxt  = out_before_r;
    out_after_nxt   = out_after_r;
    out_last_nxt    = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (rdata.op)
            OP_INIT: begin
              step_nxt  = '0;
              state_nxt = ST_INIT;
            end
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_SETCUR: begin
              col_nxt       = rdata.col;
              row_nxt       = rdata.row;
              addr_last_nxt = 1'b1;
              state_nxt     = ST_ADDR;
            end
            OP_CHAR: begin
              if (rdata.char_code == CHAR_NEWLINE) begin
                col_nxt       = '0;
                row_nxt       = row_next;
                addr_last_nxt = 1'b1;
                state_nxt     = ST_ADDR;
              end else begin
                char_nxt   = rdata.char_code;
                is_int_nxt = 1'b0;
                state_nxt  = ST_CHAR;
              end
            end
            OP_INT: begin
              is_int_nxt   = 1'b1;
              neg_pend_nxt = rdata.neg;
              idx_nxt      = rdata.top_idx;
              bcd_nxt      = rdata.bcd;
              state_nxt    = ST_CHAR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = 1'b0;
          out_byte_nxt    = icmd.cmd;
          out_before_nxt  = icmd.before_ms;
          out_after_nxt   = icmd.after_ms;
          out_last_nxt    = (step_r == IDX_W'(INIT_LEN - 1));
          if (step_r == IDX_W'(INIT_LEN - 1)) begin
            col_nxt   = '0;
            row_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = 1'b0;
          out_byte_nxt    = CMD_CLEAR;
          out_before_nxt  = 8'd0;
          out_after_nxt   = PAUSE_CLEAR_MS;
          out_last_nxt    = 1'b1;
          col_nxt         = '0;
          row_nxt         = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_ADDR: begin
        if (emit_ok) begin
          // Set-DDRAM-address: row 1 starts at 0x40 and the column never carries into it.
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = 1'b0;
          out_byte_nxt    = {1'b1, row_r, col_r};
          out_before_nxt  = 8'd0;
          out_after_nxt   = 2'd0;
          out_last_nxt    = addr_last_r;
          state_nxt       = addr_last_r ? ST_IDLE : ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = 1'b1;
          out_byte_nxt    = cur_char;
          out_before_nxt  = 8'd0;
          out_after_nxt   = 2'd0;
          out_last_nxt    = !more && !wrap;
          if (neg_pend_r) begin
            neg_pend_nxt = 1'b0;
          end else if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
          if (wrap) begin
            col_nxt       = '0;
            row_nxt       = row_next;
            addr_last_nxt = !more;
            state_nxt     = ST_ADDR;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = more ? ST_CHAR : ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r        <= step_nxt;
    char_r        <= char_nxt;
    is_int_r      <= is_int_nxt;
    neg_pend_r    <= neg_pend_nxt;
    idx_r         <= idx_nxt;
    bcd_r         <= bcd_nxt;
    addr_last_r   <= addr_last_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_byte_r    <= out_byte_nxt;
    out_before_r  <= out_before_nxt;
    out_after_r   <= out_after_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.is_data         = out_is_data_r;
  assign out_if.byte_value      = out_byte_r;
  assign out_if.pause_before_ms = out_before_r;
  assign out_if.pause_after_ms  = out_after_r;
  assign out_if.last            = out_last_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(NUM_COLS))
    else $error("cursor column out of range");

  a_pause_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_after_r != 2'd0) |-> !out_is_data_r && (out_byte_r == CMD_CLEAR))
    else $error("pause after a transfer that is not a clear command");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && out_valid_r |-> out_last_r)
    else $error("sequencer went idle before the final transfer");

endmodule

`default_nettype wire

// ===== sv/char_lcd_text_writer.sv =====
// Top level of the character-LCD text writer: contrast register, front, queue, back.
// Depends on cltw_pkg, cltw_ifs, cltw_front, cltw_queue and cltw_back.
`default_nettype none

// Usage: text requests arrive as words on in_if (valid/ready). Each request turns into
// one or more panel transfers on out_if (valid/ready): a register-select bit, a byte,
// pauses in milliseconds before and after, and a last flag on the final transfer of
// the request. Init gives ten commands, clear one, set cursor one, a character one or
// two (data plus a set-address command when the line wraps), and an integer up to
// eleven characters plus wraps. Unknown kinds are taken and dropped.
// Flow: a non-integer request goes through the queue and the back end's state register
// to the output register; an integer request first runs its 32-step binary-to-BCD
// conversion. The back end then gives one transfer per cycle while out_if is ready,
// passing its idle state between requests to fetch the next queued operation. The
// front end works on the following request while the back end is still sending, up
// to two queued operations; the integer conversion unit sets the pace for integers.
// When the receiver stalls, the output register holds its word and the back end and
// then the queue fill up before in_if drops ready. Reset (rst_n low, synchronous)
// empties the queue, drops any pending transfer, puts the cursor at row 0, column 0
// and sets contrast to 32. cfg_we writes contrast and must only be used while idle.
module char_lcd_text_writer #(
  parameter int NUM_COLS = cltw_pkg::NUM_COLS_DFLT,
  parameter int NUM_ROWS = cltw_pkg::NUM_ROWS_DFLT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cltw_pkg::CONTRAST_W-1:0] cfg_wdata,
  cltw_in_if.sink                              in_if,
  cltw_out_if.source                           out_if
);
  import cltw_pkg::*;

  logic [CONTRAST_W-1:0] contrast_r;
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  entry_t                wdata;
  entry_t                rdata;

  // Contrast is only read by the init sequence, so a plain register does.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r <= CONTRAST_RST;
    end else if (cfg_we) begin
      contrast_r <= cfg_wdata;
    end
  end

  // Front end classifies requests and converts integers to decimal digits.
  cltw_front #(
    .NUM_COLS(NUM_COLS),
    .NUM_ROWS(NUM_ROWS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .push  (push),
    .wdata (wdata),
    .q_full(q_full)
  );

  // Operation queue decouples the two halves.
  cltw_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(wdata),
    .full (q_full),
    .pop  (pop),
    .rdata(rdata),
    .empty(q_empty)
  );

  // Back end sequences the transfers and owns the cursor.
  cltw_back #(
    .NUM_COLS(NUM_COLS),
    .NUM_ROWS(NUM_ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .rdata   (rdata),
    .q_empty (q_empty),
    .pop     (pop),
    .contrast(contrast_r),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire
